>>> rtl/rfba_pkg.sv
// Shared constants, types and codes of the ring free-list block allocator.
// Depends on nothing; the ring store and the top level both use it.
`default_nettype none

package rfba_pkg;

    // Pool geometry
    localparam int unsigned NUM_BLOCKS  = 1024;
    localparam int unsigned BLOCK_BYTES = 65536;   // must be a power of two
    localparam logic [31:0] POOL_BASE   = 32'h0200_0000;

    // Derived widths and values
    localparam int unsigned BLK_W       = $clog2(NUM_BLOCKS);
    localparam int unsigned CNT_W       = $clog2(NUM_BLOCKS + 1);
    localparam int unsigned BLOCK_SHIFT = $clog2(BLOCK_BYTES);
    localparam logic [63:0] POOL_BYTES  = 64'(NUM_BLOCKS) * 64'(BLOCK_BYTES);
    localparam logic [BLK_W-1:0] LAST_BLK = BLK_W'(NUM_BLOCKS - 1);

    // Request codes
    typedef enum logic [0:0] {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } func_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_BADADDR = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    // Sequencer states, one-hot
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

endpackage

`default_nettype wire

>>> rtl/ring_free_list_block_allocator_top.sv
// Top level of the ring free-list block allocator: request sequencer,
// address checks and pointers. Depends on rfba_pkg and rfba_ring.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------
//  request   | start, busy            | func, free_addr
//  result    | done (one-cycle pulse) | alloc_addr, status
//
// A request runs as the ring RAM read at the head pointer in the
// transfer cycle, then the check, pointer update and write-back.
// The result shows in the cycle after that; a new request may transfer in that
// same cycle, and none is taken while a request executes.
// Reset leaves the ring full, holding blocks 0 to NUM_BLOCKS-2, no RAM clearing pass.
// The receiver cannot stall; results are never held.
`default_nettype none

module ring_free_list_block_allocator_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        func,
    input  wire logic [31:0] free_addr,
    output logic             done,
    output logic [31:0]      alloc_addr,
    output logic [1:0]       status
);

    localparam int unsigned BW = rfba_pkg::BLK_W;

    rfba_pkg::state_t  state_reg, state_next;
    logic [BW-1:0]     head_reg, head_next;
    logic [BW-1:0]     tail_reg, tail_next;
    logic              func_reg;
    logic [31:0]       addr_reg;
    logic              done_reg, done_next;
    logic [31:0]       alloc_addr_reg, alloc_addr_next;
    rfba_pkg::status_t status_reg, status_next;

    logic              accept;
    logic              exec;
    logic [BW-1:0]     rd_data;
    logic              wr_en;
    logic [BW-1:0]     wr_idx;
    logic [BW-1:0]     wr_data;
    logic [32:0]       off;
    logic [63:0]       off64;
    logic              addr_ok;
    logic [BW-1:0]     tail_adv;

    function automatic logic [BW-1:0] ring_next(input logic [BW-1:0] p);
        ring_next = (p == rfba_pkg::LAST_BLK) ? '0 : p + BW'(1);
    endfunction

    assign exec   = (state_reg == rfba_pkg::S_EXEC);
    assign busy   = exec;
    assign accept = start && !busy;

    // Hold the request payload and register the result fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            addr_reg <= free_addr;
        end
        alloc_addr_reg <= alloc_addr_next;
        status_reg     <= status_next;
    end

    rfba_ring u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_idx  (head_reg),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data)
    );

    // Check the freed address against the pool, derive its block number and the next tail
    always_comb
    begin
        off     = {1'b0, addr_reg} - {1'b0, rfba_pkg::POOL_BASE};
        off64   = 64'(off[31:0]);
        addr_ok = !off[32] && (off64 < rfba_pkg::POOL_BYTES)
                  && (off64[rfba_pkg::BLOCK_SHIFT-1:0] == '0);
        wr_data = off64[rfba_pkg::BLOCK_SHIFT +: BW];
        tail_adv = ring_next(tail_reg);
    end

    // Decide the outcome, advance pointers, write back the ring
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        done_next       = 1'b0;
        alloc_addr_next = alloc_addr_reg;
        status_next     = status_reg;
        wr_en           = 1'b0;
        wr_idx          = tail_adv;
        unique case (state_reg)
            rfba_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = rfba_pkg::S_EXEC;
                end
            end
            rfba_pkg::S_EXEC:
            begin
                state_next      = rfba_pkg::S_IDLE;
                done_next       = 1'b1;
                alloc_addr_next = '0;
                status_next     = rfba_pkg::ST_OK;
                if (func_reg == rfba_pkg::FUNC_ALLOC)
                begin
                    if (head_reg == tail_reg)
                    begin
                        status_next = rfba_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        head_next       = ring_next(head_reg);
                        alloc_addr_next = rfba_pkg::POOL_BASE
                                          + (32'(rd_data) << rfba_pkg::BLOCK_SHIFT);
                    end
                end
                else
                begin
                    priority if (!addr_ok)
                    begin
                        status_next = rfba_pkg::ST_BADADDR;
                    end
                    else if (tail_adv == head_reg)
                    begin
                        status_next = rfba_pkg::ST_FULL;
                    end
                    else
                    begin
                        tail_next = tail_adv;
                        wr_en     = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = rfba_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rfba_pkg::S_IDLE;
            head_reg  <= '0;
            tail_reg  <= rfba_pkg::LAST_BLK;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            done_reg  <= done_next;
        end
    end

    assign done       = done_reg;
    assign alloc_addr = alloc_addr_reg;
    assign status     = status_reg;

`ifndef SYNTHESIS
    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted request did not enter execution");
    a_exec_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("execution cycle did not give exactly one result");
    a_done_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without execution");
    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != rfba_pkg::ST_OK)) |-> (alloc_addr == 32'd0))
        else $error("failed request returned a nonzero address");
    a_ptr_one_move: assert property (@(posedge clk) disable iff (!rst_n)
        !((head_reg != $past(head_reg)) && (tail_reg != $past(tail_reg))))
        else $error("head and tail moved on the same request");
`endif

endmodule

`default_nettype wire

>>> rtl/rfba_ring.sv
// Free-list ring store: one synchronous RAM of block numbers with a fill count.
// Entries never written since reset read back as their own index. Uses rfba_pkg.
`default_nettype none

module rfba_ring (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       rd_en,
    input  wire logic [rfba_pkg::BLK_W-1:0] rd_idx,
    output logic      [rfba_pkg::BLK_W-1:0] rd_data,
    input  wire logic                       wr_en,
    input  wire logic [rfba_pkg::BLK_W-1:0] wr_idx,
    input  wire logic [rfba_pkg::BLK_W-1:0] wr_data
);

    logic [rfba_pkg::BLK_W-1:0] mem [rfba_pkg::NUM_BLOCKS];
    logic [rfba_pkg::BLK_W-1:0] mem_q;
    logic [rfba_pkg::BLK_W-1:0] rd_idx_reg;
    logic                       rd_fresh_reg;
    logic                       rd_fresh_next;
    logic [rfba_pkg::CNT_W-1:0] fill_reg;
    logic [rfba_pkg::CNT_W-1:0] fill_next;

    // Write and read the ring RAM
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q      <= mem[rd_idx];
            rd_idx_reg <= rd_idx;
        end
    end

    // Writes land in index order from zero, so the fill count marks written entries
    always_comb
    begin
        fill_next = fill_reg;
        if (wr_en && (fill_reg != rfba_pkg::CNT_W'(rfba_pkg::NUM_BLOCKS)))
        begin
            fill_next = fill_reg + rfba_pkg::CNT_W'(1);
        end
        rd_fresh_next = rd_fresh_reg;
        if (rd_en)
        begin
            rd_fresh_next = ({1'b0, rd_idx} >= rfba_pkg::CNT_W'(fill_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            rd_fresh_reg <= 1'b1;
        end
        else
        begin
            fill_reg     <= fill_next;
            rd_fresh_reg <= rd_fresh_next;
        end
    end

    // Substitute the reset contents for entries not yet written
    assign rd_data = rd_fresh_reg ? rd_idx_reg : mem_q;

endmodule

`default_nettype wire

>>> tb/rfba_result_checker.sv
// Result checker for the ring free-list block allocator: watches the request
// and result channels, predicts each result and compares it field by field.
// Depends on rfba_pkg for the pool geometry, request codes and status codes.

module rfba_result_checker
    import rfba_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic        func,
    input  wire logic [31:0] free_addr,
    input  wire logic        done,
    input  wire logic [31:0] alloc_addr,
    input  wire logic [1:0]  status,
    output int               fail_count,
    output int               outstanding
);

    typedef struct packed {
        logic [31:0] addr;
        status_t     st;
    } alloc_result_t;

    // Shadow copy of the free list and its pointers
    logic [BLK_W-1:0] shadow_ring [NUM_BLOCKS];
    logic [BLK_W-1:0] shadow_head;
    logic [BLK_W-1:0] shadow_tail;

    alloc_result_t expected_results [$];

    function automatic logic [BLK_W-1:0] ring_advance(input logic [BLK_W-1:0] p);
        return (p == LAST_BLK) ? '0 : p + 1'b1;
    endfunction

    // Apply one request to the shadow state and return the result it produces
    function automatic alloc_result_t serve_request(input func_t f, input logic [31:0] a);
        alloc_result_t    r;
        logic [63:0]      offset;
        logic [63:0]      blk;
        logic [BLK_W-1:0] nxt;
        r.addr = '0;
        r.st   = ST_OK;
        if (f == FUNC_ALLOC)
        begin
            if (shadow_head == shadow_tail)
                r.st = ST_EMPTY;
            else
            begin
                r.addr = 32'(64'(POOL_BASE) + 64'(shadow_ring[shadow_head]) * 64'(BLOCK_BYTES));
                shadow_head = ring_advance(shadow_head);
            end
        end
        else if (a < POOL_BASE)
            r.st = ST_BADADDR;
        else
        begin
            offset = 64'(a) - 64'(POOL_BASE);
            blk    = offset / 64'(BLOCK_BYTES);
            if ((offset % 64'(BLOCK_BYTES)) != 0 || blk >= 64'(NUM_BLOCKS))
                r.st = ST_BADADDR;
            else
            begin
                nxt = ring_advance(shadow_tail);
                if (nxt == shadow_head)
                    r.st = ST_FULL;
                else
                begin
                    shadow_tail = nxt;
                    shadow_ring[shadow_tail] = BLK_W'(blk);
                end
            end
        end
        return r;
    endfunction

    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    // Check each result transfer, then predict any request transfer of the same edge
    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BLOCKS; i++)
                shadow_ring[i] = BLK_W'(i);
            shadow_head = '0;
            shadow_tail = LAST_BLK;
            expected_results.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                    report_failure($sformatf("result with no request outstanding: alloc_addr %h status %0d",
                                             alloc_addr, status));
                else
                begin
                    want = expected_results.pop_front();
                    if (alloc_addr !== want.addr || status !== want.st)
                        report_failure($sformatf({"result mismatch: expected alloc_addr %h status %0d,",
                                                  " got alloc_addr %h status %0d"},
                                                 want.addr, want.st, alloc_addr, status));
                end
            end
            if (start && !busy)
                expected_results.push_back(serve_request(func_t'(func), free_addr));
        end
        outstanding = expected_results.size();
    end

endmodule

>>> tb/ring_free_list_block_allocator_top_tb.sv
// Testbench top for the ring free-list block allocator: clock, reset, request
// stimulus and verdict. Depends on rfba_pkg, the allocator and rfba_result_checker.

module ring_free_list_block_allocator_top_tb;
    import rfba_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int MIXED_ITEMS = 830;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic        func      = FUNC_ALLOC;
    logic [31:0] free_addr = '0;
    logic        busy;
    logic        done;
    logic [31:0] alloc_addr;
    logic [1:0]  status;

    int fail_count;
    int outstanding;
    int idle_cycles = 0;
    bit no_gaps     = 1'b0;

    // 12-unit clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    ring_free_list_block_allocator_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .free_addr  (free_addr),
        .done       (done),
        .alloc_addr (alloc_addr),
        .status     (status)
    );

    rfba_result_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .free_addr   (free_addr),
        .done        (done),
        .alloc_addr  (alloc_addr),
        .status      (status),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Watchdog: end the run after too many cycles with no transfer
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("ring_free_list_block_allocator_top_tb failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic [31:0] block_addr(input int unsigned blk);
        return 32'(64'(POOL_BASE) + 64'(blk) * 64'(BLOCK_BYTES));
    endfunction

    // Mostly good block addresses, the rest misaligned, out of the pool or arbitrary
    function automatic logic [31:0] pick_free_addr();
        int unsigned kind;
        kind = $urandom_range(0, 99);
        if (kind < 70)
            return block_addr($urandom_range(0, NUM_BLOCKS - 1));
        if (kind < 80)
            return block_addr($urandom_range(0, NUM_BLOCKS - 1)) + $urandom_range(1, BLOCK_BYTES - 1);
        if (kind < 87)
            return $urandom_range(0, POOL_BASE - 1);
        if (kind < 94)
            return $urandom_range(32'(64'(POOL_BASE) + POOL_BYTES), 32'hFFFF_FFFF);
        return $urandom();
    endfunction

    // Present one request after a random gap and hold it until it transfers
    task automatic issue(input func_t f, input logic [31:0] a);
        int gap;
        if ($urandom_range(0, 39) == 0)
            no_gaps = !no_gaps;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        if (gap != 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start     = 1'b1;
        func      = f;
        free_addr = a;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // Hold off requests until every expected result has arrived
    task automatic settle();
        start = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed: full ring at reset, bad addresses, double free
        issue(FUNC_FREE, block_addr(5));
        issue(FUNC_FREE, POOL_BASE);
        issue(FUNC_FREE, block_addr(NUM_BLOCKS - 1));
        issue(FUNC_ALLOC, 32'hFFFF_FFFF);
        issue(FUNC_ALLOC, 32'h0000_0000);
        issue(FUNC_ALLOC, $urandom());
        issue(FUNC_FREE, block_addr(NUM_BLOCKS - 1));
        issue(FUNC_FREE, block_addr(1));
        issue(FUNC_FREE, block_addr(1));
        issue(FUNC_FREE, POOL_BASE + 32'd1);
        issue(FUNC_FREE, POOL_BASE + BLOCK_BYTES - 1);
        issue(FUNC_FREE, POOL_BASE + BLOCK_BYTES / 2);
        issue(FUNC_FREE, 32'h0000_0000);
        issue(FUNC_FREE, POOL_BASE - 32'd1);
        issue(FUNC_FREE, POOL_BASE - BLOCK_BYTES);
        issue(FUNC_FREE, 32'(64'(POOL_BASE) + POOL_BYTES));
        issue(FUNC_FREE, 32'hFFFF_FFFF);
        issue(FUNC_FREE, 32'hFFFF_0000);
        issue(FUNC_ALLOC, $urandom());
        issue(FUNC_ALLOC, $urandom());
        settle();

        // Mixed traffic: allocation-heavy first half, free-heavy second half
        for (int n = 0; n < MIXED_ITEMS; n++)
        begin
            if ($urandom_range(0, 99) < ((n < MIXED_ITEMS / 2) ? 80 : 30))
                issue(FUNC_ALLOC, $urandom());
            else
                issue(FUNC_FREE, pick_free_addr());
            if ($urandom_range(0, 199) == 0)
                settle();
        end

        settle();
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("ring_free_list_block_allocator_top_tb passed");
        else
            $display("ring_free_list_block_allocator_top_tb failed");
        $finish;
    end

endmodule

>>> ring_free_list_block_allocator_top.f
rtl/rfba_pkg.sv
rtl/rfba_ring.sv
rtl/ring_free_list_block_allocator_top.sv
tb/rfba_result_checker.sv
tb/ring_free_list_block_allocator_top_tb.sv
